### src/audio_fifo_adaptive_packetizer_core_defines.svh
// Assertion macros shared by the audio FIFO packetizer RTL.
`ifndef AUDIO_FIFO_ADAPTIVE_PACKETIZER_CORE_DEFINES_SVH
`define AUDIO_FIFO_ADAPTIVE_PACKETIZER_CORE_DEFINES_SVH

// The check holds in the same cycle as the condition.
`define AFAP_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The check holds in the cycle after the condition.
`define AFAP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### src/afap_pkg.sv
// Types, constants and helpers shared by the audio FIFO packetizer modules.
package afap_pkg;

    localparam int FIFO_DEPTH         = 256;
    localparam int MAX_PACKET_SAMPLES = 64;

    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);
    localparam int SAMPLE_W   = 24;
    localparam int NOM_W      = 7;
    localparam int PKT_W      = 6;
    localparam int WM_W       = 9;
    localparam int CNT_W      = $clog2(MAX_PACKET_SAMPLES + 1);
    localparam int PREBUF_W   = NOM_W + PKT_W;
    localparam int CMP_W      = (LEVEL_W > PREBUF_W) ? LEVEL_W : PREBUF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(FIFO_DEPTH);
    localparam logic [NOM_W-1:0]   PKT_CAP    = NOM_W'(MAX_PACKET_SAMPLES);

    localparam logic [NOM_W-1:0] RST_NOMINAL  = NOM_W'(48);
    localparam logic [NOM_W-1:0] RST_MAX      = NOM_W'(50);
    localparam logic [PKT_W-1:0] RST_PREBUF   = PKT_W'(16);
    localparam logic [PKT_W-1:0] RST_TARGET   = PKT_W'(16);
    localparam logic [WM_W-1:0]  RST_HIGH_WM  = WM_W'(192);
    localparam logic [WM_W-1:0]  RST_CRIT_WM  = WM_W'(224);

    typedef enum logic [1:0] {
        CMD_PUSH       = 2'd0,
        CMD_FRAME_DONE = 2'd1,
        CMD_SERVICE    = 2'd2,
        CMD_STREAM     = 2'd3
    } afap_cmd_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_PACKET = 2'd1,
        ST_PREBUF = 2'd2,
        ST_SHORT  = 2'd3
    } afap_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOMINAL = 3'd0,
        REG_MAX     = 3'd1,
        REG_PREBUF  = 3'd2,
        REG_TARGET  = 3'd3,
        REG_HIGH_WM = 3'd4,
        REG_CRIT_WM = 3'd5
    } afap_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } afap_state_t;

    typedef struct packed {
        logic item_load;
        logic exec;
        logic pop;
    } afap_dp_cmd_t;

    typedef struct packed {
        logic emit_pkt;
        logic last_pop;
    } afap_dp_status_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                sample_valid;
        logic                last_in_packet;
        logic                repeated;
        logic                dropped_oldest;
        logic [LEVEL_W-1:0]  buffer_level;
        logic [PKT_W-1:0]    queued;
        logic                started;
        logic                start_now;
        logic                service_wanted;
        afap_status_t        step_status;
    } afap_result_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

endpackage

### src/afap_datapath.sv
// Datapath: configuration, FIFO store and pointers, packet sizing and the result word.
module afap_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  afap_pkg::afap_dp_cmd_t               cmd,
    output afap_pkg::afap_dp_status_t            status,
    input  logic [1:0]                           command,
    input  logic [afap_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                 end_of_block,
    input  logic                                 stream_on,
    input  logic                                 cfg_we,
    input  logic [afap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afap_pkg::CFG_DATA_W-1:0]      cfg_data,
    output afap_pkg::afap_result_t               result
);
    import afap_pkg::*;

    logic [NOM_W-1:0]    nominal_reg;
    logic [NOM_W-1:0]    max_reg;
    logic [PKT_W-1:0]    prebuf_reg;
    logic [PKT_W-1:0]    target_reg;
    logic [WM_W-1:0]     high_wm_reg;
    logic [WM_W-1:0]     crit_wm_reg;

    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic [PKT_W-1:0]    queued_reg, queued_next;
    logic                started_reg, started_next;
    logic                active_reg, active_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                start_now_reg, start_now_next;

    afap_cmd_t           item_cmd_reg;
    logic [SAMPLE_W-1:0] item_sample_reg;
    logic                item_eob_reg;
    logic                item_son_reg;

    logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                mem_we;

    afap_result_t        res_reg, res_next;

    logic [PREBUF_W-1:0] prebuf_need;
    logic                hold_pre;
    logic [NOM_W-1:0]    n_a, n_b, n_pkt;
    logic                emit;
    logic [PKT_W-1:0]    queued_inc;
    logic                start_chk;

    // Packet sizing and the prebuffer and start checks.
    always_comb
    begin
        prebuf_need = PREBUF_W'(nominal_reg) * PREBUF_W'(prebuf_reg);
        hold_pre    = !started_reg && (CMP_W'(level_reg) < CMP_W'(prebuf_need));
        n_a = nominal_reg;
        if ((CMP_W'(level_reg) > CMP_W'(high_wm_reg)) && (nominal_reg < max_reg))
        begin
            n_a = nominal_reg + 1'b1;
        end
        n_b = n_a;
        if ((CMP_W'(level_reg) > CMP_W'(crit_wm_reg)) && (n_a < max_reg))
        begin
            n_b = n_a + 1'b1;
        end
        n_pkt      = (n_b > PKT_CAP) ? PKT_CAP : n_b;
        emit       = (queued_reg < target_reg) && (CMP_W'(level_reg) >= CMP_W'(n_pkt));
        queued_inc = queued_reg + PKT_W'(emit);
        start_chk  = !started_reg && (queued_inc >= prebuf_reg);
    end

    assign status.emit_pkt = (item_cmd_reg == CMD_SERVICE) && active_reg && !hold_pre
                             && emit && (n_pkt != '0);
    assign status.last_pop = (count_reg == CNT_W'(1));

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        level_next     = level_reg;
        held_next      = held_reg;
        queued_next    = queued_reg;
        started_next   = started_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        start_now_next = start_now_reg;
        mem_we         = 1'b0;
        res_next       = res_reg;

        if (cmd.exec)
        begin
            res_next                = '0;
            res_next.last_in_packet = 1'b1;
            case (item_cmd_reg)
                CMD_STREAM:
                begin
                    active_next  = item_son_reg;
                    started_next = 1'b0;
                    queued_next  = '0;
                    held_next    = '0;
                    wp_next      = '0;
                    rp_next      = '0;
                    level_next   = '0;
                end
                CMD_PUSH:
                begin
                    if (active_reg)
                    begin
                        mem_we  = 1'b1;
                        wp_next = ptr_inc(wp_reg);
                        if (level_reg == LEVEL_FULL)
                        begin
                            // Full: the oldest sample makes room, level stays put.
                            rp_next                 = ptr_inc(rp_reg);
                            res_next.dropped_oldest = 1'b1;
                        end
                        else
                        begin
                            level_next = level_reg + 1'b1;
                        end
                        res_next.service_wanted = item_eob_reg && !started_reg;
                    end
                end
                CMD_FRAME_DONE:
                begin
                    if (active_reg)
                    begin
                        if (queued_reg != '0)
                        begin
                            queued_next = queued_reg - 1'b1;
                        end
                        res_next.service_wanted = 1'b1;
                    end
                end
                CMD_SERVICE:
                begin
                    if (active_reg)
                    begin
                        if (hold_pre)
                        begin
                            res_next.step_status = ST_PREBUF;
                        end
                        else
                        begin
                            queued_next = queued_inc;
                            if (start_chk)
                            begin
                                started_next = 1'b1;
                            end
                            res_next.start_now   = start_chk;
                            start_now_next       = start_chk;
                            res_next.step_status = emit ? ST_PACKET : ST_SHORT;
                            count_next           = CNT_W'(n_pkt);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res_next.buffer_level = level_next;
            res_next.queued       = queued_next;
            res_next.started      = started_next;
        end
        else if (cmd.pop)
        begin
            res_next                = '0;
            res_next.sample_valid   = 1'b1;
            res_next.last_in_packet = (count_reg == CNT_W'(1));
            res_next.start_now      = start_now_reg;
            res_next.step_status    = ST_PACKET;
            if (level_reg != '0)
            begin
                res_next.sample_out = rdata_reg;
                held_next           = rdata_reg;
                rp_next             = ptr_inc(rp_reg);
                level_next          = level_reg - 1'b1;
            end
            else
            begin
                res_next.sample_out = held_reg;
                res_next.repeated   = 1'b1;
            end
            count_next            = count_reg - 1'b1;
            res_next.buffer_level = level_next;
            res_next.queued       = queued_reg;
            res_next.started      = started_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg   <= RST_NOMINAL;
            max_reg       <= RST_MAX;
            prebuf_reg    <= RST_PREBUF;
            target_reg    <= RST_TARGET;
            high_wm_reg   <= RST_HIGH_WM;
            crit_wm_reg   <= RST_CRIT_WM;
            wp_reg        <= '0;
            rp_reg        <= '0;
            level_reg     <= '0;
            held_reg      <= '0;
            queued_reg    <= '0;
            started_reg   <= 1'b0;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            start_now_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            level_reg     <= level_next;
            held_reg      <= held_next;
            queued_reg    <= queued_next;
            started_reg   <= started_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            start_now_reg <= start_now_next;
            if (cfg_we)
            begin
                unique case (afap_reg_t'(cfg_index))
                    REG_NOMINAL: nominal_reg <= cfg_data[NOM_W-1:0];
                    REG_MAX:     max_reg     <= cfg_data[NOM_W-1:0];
                    REG_PREBUF:  prebuf_reg  <= cfg_data[PKT_W-1:0];
                    REG_TARGET:  target_reg  <= cfg_data[PKT_W-1:0];
                    REG_HIGH_WM: high_wm_reg <= cfg_data[WM_W-1:0];
                    REG_CRIT_WM: crit_wm_reg <= cfg_data[WM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.item_load)
        begin
            item_cmd_reg    <= afap_cmd_t'(command);
            item_sample_reg <= sample;
            item_eob_reg    <= end_of_block;
            item_son_reg    <= stream_on;
        end
    end

    // Sample store; the read port follows the next read pointer so that the
    // registered data belongs to the current read pointer but for a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= item_sample_reg;
        end
        rdata_reg <= mem[rp_next];
    end

    assign result = res_reg;

endmodule

### src/afap_ctrl.sv
// Controller: sequences one word at a time and owns the output valid flag.
module afap_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  afap_pkg::afap_dp_status_t   status,
    output afap_pkg::afap_dp_cmd_t      cmd
);
    import afap_pkg::*;

    afap_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;
    logic        load;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec = 1'b1;
                    if (status.emit_pkt)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.pop = 1'b1;
                    load    = 1'b1;
                    if (status.last_pop)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/audio_fifo_adaptive_packetizer_core.sv
// Top level of the audio FIFO with adaptive isochronous packetizer.
//
// Input words (command, sample, end_of_block, stream_on) arrive on a valid/ready
// channel. Command 0 pushes a 24-bit sample into a 256-entry ring FIFO, 1 marks
// a frame as done, 2 asks for a service step that may cut one packet, and 3 sets
// the stream on or off and empties the FIFO and the packet queue.
// Every word gives one result word, except a service step that emits a packet,
// which gives one result word per packet sample; last_in_packet marks the
// final result word of each input word.
// A word is taken in the idle state and executed in the exec state once the
// output register is free; a packet's samples then follow from the emit state,
// where the single read port of the sample store delivers one sample per cycle
// while the receiver keeps up. A single result word enters the output register
// from the exec state, each packet sample from the emit state.
// Results sit in an output register; a new input word is accepted while a
// result still waits there, and a stalled receiver only holds up the next
// result word, never loses or repeats one.
// The configuration channel is always ready; writes are meant for times when
// no word is in flight.
// Reset restores the register defaults, stops the stream and empties the
// FIFO; the sample store itself is not cleared and needs no clearing pass.
module audio_fifo_adaptive_packetizer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic [afap_pkg::SAMPLE_W-1:0]         sample,
    input  logic                                  end_of_block,
    input  logic                                  stream_on,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [afap_pkg::SAMPLE_W-1:0]         sample_out,
    output logic                                  sample_valid,
    output logic                                  last_in_packet,
    output logic                                  repeated,
    output logic                                  dropped_oldest,
    output logic [afap_pkg::LEVEL_W-1:0]          buffer_level,
    output logic [afap_pkg::PKT_W-1:0]            queued,
    output logic                                  started,
    output logic                                  start_now,
    output logic                                  service_wanted,
    output logic [1:0]                            step_status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [afap_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [afap_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import afap_pkg::*;

`include "audio_fifo_adaptive_packetizer_core_defines.svh"

    afap_dp_cmd_t    dp_cmd;
    afap_dp_status_t dp_status;
    afap_result_t    result;

    // Registers can be written at any cycle, so the port never pushes back.
    assign cfg_ready = 1'b1;

    afap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    afap_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .command      (command),
        .sample       (sample),
        .end_of_block (end_of_block),
        .stream_on    (stream_on),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result)
    );

    // Unpack the registered result word onto the output ports.
    assign sample_out     = result.sample_out;
    assign sample_valid   = result.sample_valid;
    assign last_in_packet = result.last_in_packet;
    assign repeated       = result.repeated;
    assign dropped_oldest = result.dropped_oldest;
    assign buffer_level   = result.buffer_level;
    assign queued         = result.queued;
    assign started        = result.started;
    assign start_now      = result.start_now;
    assign service_wanted = result.service_wanted;
    assign step_status    = result.step_status;

    // A word is worked on alone: after an accept the input side closes.
    `AFAP_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready,
        "input accepted while a word is still in flight")

    // Only packet results carry samples.
    `AFAP_ASSERT_NOW(a_sample_in_packet, out_valid && sample_valid,
        step_status == ST_PACKET, "sample result without packet status")

    // A drop only happens at a full FIFO, and the level stays full.
    `AFAP_ASSERT_NOW(a_drop_keeps_full, out_valid && dropped_oldest,
        buffer_level == LEVEL_FULL, "oldest sample dropped below full level")

    // The start pulse and the started flag agree.
    `AFAP_ASSERT_NOW(a_start_sets_flag, out_valid && start_now, started,
        "start pulse without started flag")

endmodule

### tb/tb.sv
// Self-checking testbench for the audio FIFO adaptive packetizer core.
`timescale 1ns / 1ps

module tb;
    import afap_pkg::*;

    // The slowest correct run: roughly 550 input words, each with a random sender
    // gap and its pass through the block, and at most 64 result words per input
    // word, each of which may wait out a random receiver stall. This limit leaves
    // a wide margin over that.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 16;
    localparam int NO_CFG      = -1;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 25;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           command;
    logic [SAMPLE_W-1:0]  sample;
    logic                 end_of_block;
    logic                 stream_on;
    logic                 out_valid;
    logic                 out_ready;
    logic [SAMPLE_W-1:0]  sample_out;
    logic                 sample_valid;
    logic                 last_in_packet;
    logic                 repeated;
    logic                 dropped_oldest;
    logic [LEVEL_W-1:0]   buffer_level;
    logic [PKT_W-1:0]     queued;
    logic                 started;
    logic                 start_now;
    logic                 service_wanted;
    logic [1:0]           step_status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    audio_fifo_adaptive_packetizer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .sample         (sample),
        .end_of_block   (end_of_block),
        .stream_on      (stream_on),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .sample_valid   (sample_valid),
        .last_in_packet (last_in_packet),
        .repeated       (repeated),
        .dropped_oldest (dropped_oldest),
        .buffer_level   (buffer_level),
        .queued         (queued),
        .started        (started),
        .start_now      (start_now),
        .service_wanted (service_wanted),
        .step_status    (step_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // One row of the directed part. Rows marked typed carry their expected word
    // written out by hand: those are single quiet words with nothing queued and
    // transmission not started, so only the level, the service request and the
    // status differ between them. All other rows go through the packet predictor.
    typedef struct {
        int           cfg_id;
        afap_cmd_t    cmd;
        logic [23:0]  smp;
        logic         eob;
        logic         son;
        bit           typed;
        logic [8:0]   lvl;
        logic         svc;
        afap_status_t st;
    } stim_row_t;

    // Settings applied before a directed row: nominal, max, prebuffer, target,
    // high watermark, critical watermark.
    int dir_cfgs [3][6] = '{
        '{2, 4, 1, 2, 0, 256},      // small packets that grow above an empty FIFO
        '{0, 1, 1, 32, 256, 256},   // zero-size packet
        '{3, 1, 1, 2, 0, 0}         // nominal size above the maximum is kept
    };

    stim_row_t dir_rows [26] = '{
        // Stream still off after reset: all but the last command are no-ops.
        '{NO_CFG, CMD_PUSH,       24'hFFFFFF, 1'b1, 1'b1, 1'b1, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_FRAME_DONE, 24'h000000, 1'b0, 1'b1, 1'b1, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'h000000, 1'b1, 1'b0, 1'b1, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_STREAM,     24'hFFFFFF, 1'b1, 1'b0, 1'b1, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_STREAM,     24'h000000, 1'b0, 1'b1, 1'b1, 9'd0, 1'b0, ST_NONE},
        // Register defaults need far more samples than the FIFO holds, so a
        // service step is always held back by the prebuffer here.
        '{NO_CFG, CMD_PUSH,       24'hFFFFFF, 1'b1, 1'b0, 1'b1, 9'd1, 1'b1, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h000000, 1'b0, 1'b0, 1'b1, 9'd2, 1'b0, ST_NONE},
        '{NO_CFG, CMD_FRAME_DONE, 24'h123456, 1'b0, 1'b0, 1'b1, 9'd2, 1'b1, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'h654321, 1'b0, 1'b0, 1'b1, 9'd2, 1'b0, ST_PREBUF},
        '{NO_CFG, CMD_PUSH,       24'hA5A5A5, 1'b1, 1'b0, 1'b1, 9'd3, 1'b1, ST_NONE},
        // Small packets: the first one starts transmission, then the FIFO runs
        // short, then the queue fills and frame-done events retire it.
        '{0,      CMD_SERVICE,    24'h000000, 1'b0, 1'b1, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'hFFFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h5A5A5A, 1'b0, 1'b1, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h800000, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h7FFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'h000001, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'h000002, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_FRAME_DONE, 24'h000000, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_FRAME_DONE, 24'h000000, 1'b0, 1'b1, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_FRAME_DONE, 24'h000000, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{1,      CMD_SERVICE,    24'h000000, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{2,      CMD_STREAM,     24'h000000, 1'b0, 1'b1, 1'b1, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h111111, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h222222, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_PUSH,       24'h333333, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE},
        '{NO_CFG, CMD_SERVICE,    24'h000000, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0, ST_NONE}
    };

    // Packet predictor state: its own copy of the FIFO and of the registers.
    logic [23:0] fifo_mem [256];
    logic [7:0]  wr_ptr;
    logic [7:0]  rd_ptr;
    logic [8:0]  fill_level;
    logic [23:0] held_smp;
    logic [5:0]  queue_cnt;
    logic        started_f;
    logic        active_f;
    logic [6:0]  nom_cfg;
    logic [6:0]  max_cfg;
    logic [5:0]  pre_cfg;
    logic [5:0]  tgt_cfg;
    logic [8:0]  hi_cfg;
    logic [8:0]  crit_cfg;

    // Result words predicted and not yet seen, oldest first.
    afap_result_t pending_results [$];
    afap_result_t head_result;

    int  errors;
    int  cycles;
    int  words_sent;
    int  results_checked;
    int  packets_cut;
    int  drops_seen;
    int  starts_seen;
    bit  calm;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap before each word or each result; zero throughout the calm stretches.
    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Works out the result words of one accepted input word and queues them.
    task automatic predict_word(input afap_cmd_t c, input logic [23:0] s,
                                input logic eob, input logic son);
        afap_result_t r;
        int           n;
        bit           emit;
        bit           cut;
        logic [23:0]  smp;
        logic         rep;
        r = '0;
        r.last_in_packet = 1'b1;
        r.step_status = ST_NONE;
        cut = 1'b0;
        if (c == CMD_STREAM) begin
            // The store keeps its contents; only the bookkeeping is cleared.
            active_f   = son;
            started_f  = 1'b0;
            queue_cnt  = '0;
            held_smp   = '0;
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill_level = '0;
        end else if (!active_f) begin
            // An inactive stream ignores everything but a stream change.
        end else if (c == CMD_PUSH) begin
            if (fill_level == 9'd256) begin
                rd_ptr = rd_ptr + 8'd1;
                fill_level = fill_level - 9'd1;
                r.dropped_oldest = 1'b1;
                drops_seen++;
            end
            fifo_mem[wr_ptr] = s;
            wr_ptr = wr_ptr + 8'd1;
            fill_level = fill_level + 9'd1;
            r.service_wanted = eob && !started_f;
        end else if (c == CMD_FRAME_DONE) begin
            if (queue_cnt != 0) begin
                queue_cnt = queue_cnt - 6'd1;
            end
            r.service_wanted = 1'b1;
        end else if (!started_f && int'(fill_level) < int'(nom_cfg) * int'(pre_cfg)) begin
            r.step_status = ST_PREBUF;
        end else begin
            n = 0;
            emit = 1'b0;
            if (queue_cnt < tgt_cfg) begin
                // Grow by one above each watermark while below the maximum,
                // then clip to the largest packet the endpoint can carry.
                n = int'(nom_cfg);
                if (fill_level > hi_cfg && n < int'(max_cfg)) begin
                    n++;
                end
                if (fill_level > crit_cfg && n < int'(max_cfg)) begin
                    n++;
                end
                if (n > MAX_PACKET_SAMPLES) begin
                    n = MAX_PACKET_SAMPLES;
                end
                emit = int'(fill_level) >= n;
            end
            if (emit) begin
                queue_cnt = queue_cnt + 6'd1;
            end
            if (!started_f && queue_cnt >= pre_cfg) begin
                started_f = 1'b1;
                r.start_now = 1'b1;
                starts_seen++;
            end
            if (!emit) begin
                r.step_status = ST_SHORT;
            end else begin
                r.step_status = ST_PACKET;
                packets_cut++;
                if (n > 0) begin
                    cut = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (fill_level != 0) begin
                            smp = fifo_mem[rd_ptr];
                            rd_ptr = rd_ptr + 8'd1;
                            fill_level = fill_level - 9'd1;
                            held_smp = smp;
                            rep = 1'b0;
                        end else begin
                            smp = held_smp;
                            rep = 1'b1;
                        end
                        r.sample_out     = smp;
                        r.sample_valid   = 1'b1;
                        r.last_in_packet = (i == n - 1);
                        r.repeated       = rep;
                        r.buffer_level   = fill_level;
                        r.queued         = queue_cnt;
                        r.started        = started_f;
                        pending_results.push_back(r);
                    end
                end
            end
        end
        if (!cut) begin
            r.buffer_level = fill_level;
            r.queued       = queue_cnt;
            r.started      = started_f;
            pending_results.push_back(r);
        end
    endtask

    // Offers one input word and waits until the block takes it. Entered at any
    // point after a rising edge; returns at the rising edge of the handshake.
    task automatic send_word(input afap_cmd_t c, input logic [23:0] s, input logic e,
                             input logic o, input bit typed = 1'b0,
                             input afap_result_t typed_res = '0);
        int gap;
        @(negedge clk);
        gap = idle_draw();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= c;
        sample       <= s;
        end_of_block <= e;
        stream_on    <= o;
        do @(posedge clk); while (!in_ready);
        predict_word(c, s, e, o);
        if (typed) begin
            // The hand-written word replaces the predicted one.
            void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
        words_sent++;
    endtask

    // Drops valid and holds the sender back until every predicted word is in.
    task automatic pause_sender();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_one(input afap_reg_t idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_NOMINAL: nom_cfg  = 7'(val);
            REG_MAX:     max_cfg  = 7'(val);
            REG_PREBUF:  pre_cfg  = 6'(val);
            REG_TARGET:  tgt_cfg  = 6'(val);
            REG_HIGH_WM: hi_cfg   = 9'(val);
            REG_CRIT_WM: crit_cfg = 9'(val);
            default: ;
        endcase
    endtask

    // Rewrites every register, always with the block drained first.
    task automatic write_regs(input int nom, input int mx, input int pre, input int tgt,
                              input int hi, input int crit);
        pause_sender();
        write_one(REG_NOMINAL, nom);
        write_one(REG_MAX, mx);
        write_one(REG_PREBUF, pre);
        write_one(REG_TARGET, tgt);
        write_one(REG_HIGH_WM, hi);
        write_one(REG_CRIT_WM, crit);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string fname, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    // Receiver: a fresh stall before every result word, ready held until it
    // arrives.
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = idle_draw();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Every result word taken by the receiver is compared with the oldest
    // prediction, field by field.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with no word expected, sample_out %h status %h",
                         $time, sample_out, step_status);
            end else begin
                head_result = pending_results.pop_front();
                check_field("sample_out", head_result.sample_out, sample_out);
                check_field("sample_valid", 24'(head_result.sample_valid),
                            24'(sample_valid));
                check_field("last_in_packet", 24'(head_result.last_in_packet),
                            24'(last_in_packet));
                check_field("repeated", 24'(head_result.repeated), 24'(repeated));
                check_field("dropped_oldest", 24'(head_result.dropped_oldest),
                            24'(dropped_oldest));
                check_field("buffer_level", 24'(head_result.buffer_level),
                            24'(buffer_level));
                check_field("queued", 24'(head_result.queued), 24'(queued));
                check_field("started", 24'(head_result.started), 24'(started));
                check_field("start_now", 24'(head_result.start_now), 24'(start_now));
                check_field("service_wanted", 24'(head_result.service_wanted),
                            24'(service_wanted));
                check_field("step_status", 24'(head_result.step_status),
                            24'(step_status));
                results_checked++;
            end
        end
    end

    // Watchdog: a missing result word would otherwise stall the run forever.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Run stopped after %0d cycles with %0d words outstanding.",
                         cycles, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        afap_result_t typed_r;
        int           sel;
        int           burst;
        int           burst_cap;
        int           phase_start;

        // Every input known from time zero.
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_PUSH;
        sample       = '0;
        end_of_block = 1'b0;
        stream_on    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_NOMINAL;
        cfg_data     = '0;
        errors          = 0;
        words_sent      = 0;
        results_checked = 0;
        packets_cut     = 0;
        drops_seen      = 0;
        starts_seen     = 0;
        calm            = 1'b0;

        // Predictor comes up as the block does after reset.
        wr_ptr     = '0;
        rd_ptr     = '0;
        fill_level = '0;
        held_smp   = '0;
        queue_cnt  = '0;
        started_f  = 1'b0;
        active_f   = 1'b0;
        nom_cfg    = RST_NOMINAL;
        max_cfg    = RST_MAX;
        pre_cfg    = RST_PREBUF;
        tgt_cfg    = RST_TARGET;
        hi_cfg     = RST_HIGH_WM;
        crit_cfg   = RST_CRIT_WM;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: the stream off and on, the register defaults, then the
        // packet sizes and queue states one at a time.
        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg_id != NO_CFG) begin
                write_regs(dir_cfgs[dir_rows[k].cfg_id][0], dir_cfgs[dir_rows[k].cfg_id][1],
                           dir_cfgs[dir_rows[k].cfg_id][2], dir_cfgs[dir_rows[k].cfg_id][3],
                           dir_cfgs[dir_rows[k].cfg_id][4], dir_cfgs[dir_rows[k].cfg_id][5]);
            end
            typed_r = '0;
            typed_r.last_in_packet = 1'b1;
            typed_r.buffer_level   = dir_rows[k].lvl;
            typed_r.service_wanted = dir_rows[k].svc;
            typed_r.step_status    = dir_rows[k].st;
            send_word(dir_rows[k].cmd, dir_rows[k].smp, dir_rows[k].eob, dir_rows[k].son,
                      dir_rows[k].typed, typed_r);
        end

        // Overflow and oversized packets: fill the FIFO past full so the oldest
        // samples are dropped, then cut packets whose size grows past the cap
        // with both watermarks at zero. The fill runs with no idling at all.
        write_regs(64, 66, 1, 4, 0, 0);
        send_word(CMD_STREAM, 24'($urandom()), 1'b0, 1'b1);
        calm = 1'b1;
        for (int j = 0; j < 260; j++) begin
            send_word(CMD_PUSH, 24'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
        end
        calm = 1'b0;
        repeat (5) send_word(CMD_SERVICE, 24'($urandom()), 1'b0, 1'b0);
        repeat (2) send_word(CMD_FRAME_DONE, 24'($urandom()), 1'b0, 1'b0);
        send_word(CMD_SERVICE, 24'($urandom()), 1'b0, 1'b0);

        // Random part: each phase picks a setting, turns the stream on and then
        // mostly runs push blocks, service steps and frame-done events, with a
        // little noise and the odd stream change mixed in.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_regs(1, 1, 1, 1, 0, 0);
                1: write_regs(64, 64, 32, 32, 256, 256);
                default: begin
                    sel = $urandom_range(1, 6);
                    write_regs(sel, $urandom_range(1, sel + 3), $urandom_range(1, 3),
                               $urandom_range(1, 5), $urandom_range(0, 24),
                               $urandom_range(0, 36));
                end
            endcase
            calm = (ph % 3 == 2);
            send_word(CMD_STREAM, 24'($urandom()), 1'($urandom_range(0, 1)), 1'b1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    burst_cap = (2 * int'(nom_cfg) + 2 > 16) ? 16 : 2 * int'(nom_cfg) + 2;
                    burst = $urandom_range(1, burst_cap);
                    for (int j = 0; j < burst; j++) begin
                        send_word(CMD_PUSH, 24'($urandom()), j == burst - 1,
                                  1'($urandom_range(0, 1)));
                    end
                end else if (sel < 75) begin
                    send_word(CMD_SERVICE, 24'($urandom()), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else if (sel < 88) begin
                    send_word(CMD_FRAME_DONE, 24'($urandom()), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else if (sel < 93) begin
                    send_word(CMD_STREAM, 24'($urandom()), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 4) != 0);
                end else begin
                    send_word(afap_cmd_t'($urandom_range(0, 3)), 24'($urandom()),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                // Now and then let the whole pipeline run dry mid-phase.
                if ($urandom_range(0, 19) == 0) begin
                    pause_sender();
                end
            end
        end

        pause_sender();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d result words: %0d packets cut,",
                 words_sent, results_checked, packets_cut);
        $display("%0d oldest samples dropped on overflow, %0d transmission starts.",
                 drops_seen, starts_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/afap_pkg.sv
src/afap_datapath.sv
src/afap_ctrl.sv
src/audio_fifo_adaptive_packetizer_core.sv
tb/tb.sv
